### rtl/zsf_pkg.sv
// Shared types, constants and digit split for the zero-sum-free reach update block.
`default_nettype none
package zsf_pkg;

  localparam int GROUP_ORDER = 125;
  localparam int MAX_COPIES = 4;
  localparam int COPY_W = 3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_COMMIT,
    S_DONE
  } zsf_state_t;

  typedef enum logic {
    CMD_CLEAR = 1'b0,
    CMD_ADD   = 1'b1
  } zsf_cmd_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic step;
    logic commit;
  } zsf_ctrl_t;

  typedef struct packed {
    logic [2:0] x;
    logic [2:0] y;
    logic [2:0] z;
  } zsf_digits_t;

  // base-5 split of an element below GROUP_ORDER
  function automatic zsf_digits_t to_digits(input logic [6:0] e);
    zsf_digits_t d;
    logic [6:0]  r;
    logic [4:0]  s;
    if (e >= 7'd100) begin
      d.x = 3'd4;
      r = e - 7'd100;
    end else if (e >= 7'd75) begin
      d.x = 3'd3;
      r = e - 7'd75;
    end else if (e >= 7'd50) begin
      d.x = 3'd2;
      r = e - 7'd50;
    end else if (e >= 7'd25) begin
      d.x = 3'd1;
      r = e - 7'd25;
    end else begin
      d.x = 3'd0;
      r = e;
    end
    s = r[4:0];
    if (s >= 5'd20) begin
      d.y = 3'd4;
      s = s - 5'd20;
    end else if (s >= 5'd15) begin
      d.y = 3'd3;
      s = s - 5'd15;
    end else if (s >= 5'd10) begin
      d.y = 3'd2;
      s = s - 5'd10;
    end else if (s >= 5'd5) begin
      d.y = 3'd1;
      s = s - 5'd5;
    end else begin
      d.y = 3'd0;
    end
    d.z = s[2:0];
    return d;
  endfunction

endpackage
`default_nettype wire

### rtl/zsf_translate.sv
// Shared translate unit: digit-wise mod-5 shift of one 125-bit reach mask.
`default_nettype none
module zsf_translate (
  input  logic [zsf_pkg::GROUP_ORDER-1:0] src,
  input  zsf_pkg::zsf_digits_t            shift,
  output logic [zsf_pkg::GROUP_ORDER-1:0] dst,
  output logic                            zero_hit
);
  import zsf_pkg::*;

  // r[d] = g[(d - v) mod 5]
  function automatic logic [4:0] rot5(input logic [4:0] g, input logic [2:0] v);
    logic [4:0] r;
    logic [3:0] t;
    logic [3:0] idx;
    for (int d = 0; d < 5; d++) begin
      t = 4'(d) + 4'd5 - {1'b0, v};
      idx = (t >= 4'd5) ? t - 4'd5 : t;
      r[d] = g[idx[2:0]];
    end
    return r;
  endfunction

  logic [GROUP_ORDER-1:0] sa;
  logic [GROUP_ORDER-1:0] sb;
  logic [4:0]             g;
  logic [4:0]             r;

  always_comb begin
    sa = '0;
    sb = '0;
    dst = '0;
    g = '0;
    r = '0;
    for (int a = 0; a < 25; a++) begin
      sa[a*5 +: 5] = rot5(src[a*5 +: 5], shift.z);
    end
    for (int b = 0; b < 5; b++) begin
      for (int c = 0; c < 5; c++) begin
        for (int d = 0; d < 5; d++) begin
          g[d] = sa[b*25 + d*5 + c];
        end
        r = rot5(g, shift.y);
        for (int d = 0; d < 5; d++) begin
          sb[b*25 + d*5 + c] = r[d];
        end
      end
    end
    for (int k = 0; k < 25; k++) begin
      for (int d = 0; d < 5; d++) begin
        g[d] = sb[d*25 + k];
      end
      r = rot5(g, shift.x);
      for (int d = 0; d < 5; d++) begin
        dst[d*25 + k] = r[d];
      end
    end
  end

  assign zero_hit = dst[0];

endmodule
`default_nettype wire

### rtl/zsf_seq.sv
// Sequencer: walks layers and copies through the shared translate unit.
`default_nettype none
module zsf_seq #(
  parameter int MAX_SUBSET = 5,
  parameter int LW = $clog2(MAX_SUBSET + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          cmd,
  input  logic [6:0]                    element,
  input  logic [2:0]                    multiplicity,
  input  logic                          zero_hit,
  output logic                          busy,
  output logic                          done,
  output logic                          accepted,
  output logic [LW-1:0]                 layer,
  output zsf_pkg::zsf_ctrl_t            ctrl
);
  import zsf_pkg::*;

  zsf_state_t        state, state_next;
  logic [LW-1:0]     layer_next;
  logic [COPY_W-1:0] copies, copies_next;
  logic              acc, acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      layer <= '0;
      copies <= '0;
      acc <= 1'b0;
    end else begin
      state <= state_next;
      layer <= layer_next;
      copies <= copies_next;
      acc <= acc_next;
    end
  end

  always_comb begin
    state_next = state;
    layer_next = layer;
    copies_next = copies;
    acc_next = acc;
    ctrl = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DONE;
          if (cmd == CMD_CLEAR) begin
            ctrl.clear = 1'b1;
            acc_next = 1'b1;
          end else if (element >= 7'(GROUP_ORDER)) begin
            acc_next = 1'b0;
          end else if (multiplicity == 3'd0) begin
            acc_next = 1'b1;
          end else begin
            ctrl.load = 1'b1;
            layer_next = LW'(MAX_SUBSET);
            copies_next = (multiplicity > COPY_W'(MAX_COPIES)) ?
                          COPY_W'(MAX_COPIES) : multiplicity;
            state_next = S_RUN;
          end
        end
      end
      S_RUN: begin
        ctrl.step = 1'b1;
        if (zero_hit) begin
          acc_next = 1'b0;
          state_next = S_DONE;
        end else if (layer == LW'(1)) begin
          if (copies == COPY_W'(1)) begin
            state_next = S_COMMIT;
          end else begin
            copies_next = copies - COPY_W'(1);
            layer_next = LW'(MAX_SUBSET);
          end
        end else begin
          layer_next = layer - LW'(1);
        end
      end
      S_COMMIT: begin
        ctrl.commit = 1'b1;
        acc_next = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign accepted = acc;

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held past one cycle");
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command taken without going busy");
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("went idle without a result");
  a_layer_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (layer != '0))
    else $error("translate pass on layer zero");
  a_commit_then_ok: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |=> (done && accepted))
    else $error("commit not reported as accepted");

endmodule
`default_nettype wire

### rtl/zero_sum_free_reach_update.sv
// Top level: reach-set layers over Z5^3 with zero-sum-free add and clear commands.
//
// Usage:
//   Drive cmd, element and multiplicity with start high; the word is taken at a
//   clock edge where start is high and busy is low. busy stays high until the
//   result has been shown.
//   The result is one word: accepted on the cycle where done is high, for
//   exactly one cycle. The receiver cannot stall it.
//   Clear, an element of 125 or more, and multiplicity zero finish at once: done
//   in the cycle after the start.
//   An add runs one translate pass per layer and copy on the single shared
//   translate unit: MAX_SUBSET passes per copy, copies = multiplicity capped at
//   four. Then come a commit state and the done state; a zero sum stops the run
//   at the pass that finds it and leaves the stored layers untouched.
//   Reset (rst, synchronous) leaves layer 0 holding only the zero element and
//   the other layers empty, the same as a clear command.
`default_nettype none
module zero_sum_free_reach_update #(
  parameter int MAX_SUBSET = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       cmd,
  input  logic [6:0] element,
  input  logic [2:0] multiplicity,
  output logic       busy,
  output logic       done,
  output logic       accepted
);
  import zsf_pkg::*;

  localparam int LW = $clog2(MAX_SUBSET + 1);

  logic [GROUP_ORDER-1:0] reach [0:MAX_SUBSET];
  logic [GROUP_ORDER-1:0] work  [0:MAX_SUBSET];
  logic [GROUP_ORDER-1:0] moved;
  logic                   zero_hit;
  zsf_digits_t            digits;
  zsf_ctrl_t              ctrl;
  logic [LW-1:0]          layer;
  logic [LW-1:0]          src_layer;

  assign src_layer = layer - LW'(1);

  zsf_seq #(
    .MAX_SUBSET(MAX_SUBSET),
    .LW(LW)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .element(element),
    .multiplicity(multiplicity),
    .zero_hit(zero_hit),
    .busy(busy),
    .done(done),
    .accepted(accepted),
    .layer(layer),
    .ctrl(ctrl)
  );

  zsf_translate u_xlate (
    .src(work[src_layer]),
    .shift(digits),
    .dst(moved),
    .zero_hit(zero_hit)
  );

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      reach[0] <= GROUP_ORDER'(1);
      for (int w = 1; w <= MAX_SUBSET; w++) begin
        reach[w] <= '0;
      end
    end else if (ctrl.commit) begin
      for (int w = 0; w <= MAX_SUBSET; w++) begin
        reach[w] <= work[w];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int w = 0; w <= MAX_SUBSET; w++) begin
        work[w] <= reach[w];
      end
      digits <= to_digits(element);
    end else if (ctrl.step && !zero_hit) begin
      work[layer] <= work[layer] | moved;
    end
  end

endmodule
`default_nettype wire
